@@ rtl/core/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared constants, request and status codes, and the cell command type.
// ----------------------------------------------------------------------------
package ile_pkg;

    // Store size and field widths.
    localparam int CAPACITY = 64;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;

    // Read data is merged in groups of this many cells.
    localparam int GROUP    = 8;
    localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

    // Request kinds.
    localparam logic [2:0] REQ_READ       = 3'd0;
    localparam logic [2:0] REQ_INS_HEAD   = 3'd1;
    localparam logic [2:0] REQ_APPEND     = 3'd2;
    localparam logic [2:0] REQ_INS_POS    = 3'd3;
    localparam logic [2:0] REQ_DELETE     = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_RANGE     = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // Operation broadcast to every cell.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_READ,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic [CMP_W-1:0]          at;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

@@ rtl/core/ile_if.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine channels
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface ile_req_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        req_type;
    logic [ile_pkg::POS_W-1:0]         position;
    logic signed [ile_pkg::DATA_W-1:0] value_in;

    modport source (output valid, output req_type, output position, output value_in,
                    input ready);
    modport sink   (input valid, input req_type, input position, input value_in,
                    output ready);
endinterface

interface ile_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic signed [ile_pkg::DATA_W-1:0] read_value;
    logic [ile_pkg::COUNT_W-1:0]       count;

    modport source (output valid, output status, output read_value, output count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input count,
                    output ready);
endinterface

@@ rtl/core/ile_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine cell
// Holds one list entry and shifts it to or from its neighbors on insert and
// delete; presents its entry on a read that hits its place.
// ----------------------------------------------------------------------------
module ile_cell (
    input  logic                              clk,
    input  ile_pkg::cell_cmd_t                cmd,
    input  logic [ile_pkg::CMP_W-1:0]         idx,
    input  logic signed [ile_pkg::DATA_W-1:0] left_entry,
    input  logic signed [ile_pkg::DATA_W-1:0] right_entry,
    output logic signed [ile_pkg::DATA_W-1:0] entry,
    output logic signed [ile_pkg::DATA_W-1:0] rd
);

    logic signed [ile_pkg::DATA_W-1:0] entry_reg;
    logic signed [ile_pkg::DATA_W-1:0] entry_next;
    logic signed [ile_pkg::DATA_W-1:0] rd_reg;
    logic signed [ile_pkg::DATA_W-1:0] rd_next;

    // Entry update: on insert, places above the gap take the left neighbor and
    // the gap the new value; on delete, those at or above take the right one.
    always_comb
    begin
        entry_next = entry_reg;
        rd_next    = '0;
        case (cmd.op)
            ile_pkg::OP_INSERT:
            begin
                if (idx > cmd.at)
                begin
                    entry_next = left_entry;
                end
                else if (idx == cmd.at)
                begin
                    entry_next = cmd.value;
                end
            end
            ile_pkg::OP_DELETE:
            begin
                if (idx >= cmd.at)
                begin
                    entry_next = right_entry;
                end
            end
            ile_pkg::OP_READ:
            begin
                if (idx == cmd.at)
                begin
                    rd_next = entry_reg;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry and read data registers; payload only, no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule

@@ rtl/core/ile_chain.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine cell chain
// A row of cells linked to their neighbors, and a registered first level
// of the read data merge.
// ----------------------------------------------------------------------------
module ile_chain (
    input  logic                              clk,
    input  ile_pkg::cell_cmd_t                cmd,
    output logic signed [ile_pkg::DATA_W-1:0] group_rd [ile_pkg::NGROUP]
);

    logic signed [ile_pkg::DATA_W-1:0] entry_w [ile_pkg::CAPACITY];
    logic signed [ile_pkg::DATA_W-1:0] rd_w    [ile_pkg::CAPACITY];
    logic signed [ile_pkg::DATA_W-1:0] group_reg  [ile_pkg::NGROUP];
    logic signed [ile_pkg::DATA_W-1:0] group_next [ile_pkg::NGROUP];

    // The row of cells; the ends see zero from beyond the row.
    for (genvar i = 0; i < ile_pkg::CAPACITY; i++)
    begin : g_cell
        logic signed [ile_pkg::DATA_W-1:0] left_w;
        logic signed [ile_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = entry_w[i-1];
        end

        if (i == ile_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = entry_w[i+1];
        end

        ile_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .idx         (ile_pkg::CMP_W'(i)),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .rd          (rd_w[i])
        );
    end

    // Only the hit cell drives nonzero read data, so a group OR selects it.
    always_comb
    begin
        for (int g = 0; g < ile_pkg::NGROUP; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < ile_pkg::GROUP; k++)
            begin
                if (g * ile_pkg::GROUP + k < ile_pkg::CAPACITY)
                begin
                    group_next[g] = group_next[g] | rd_w[g * ile_pkg::GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg <= group_next;
    end

    assign group_rd = group_reg;

endmodule

@@ rtl/core/indexed_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered store of signed 32-bit values with read, insert and delete at a
// position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Fields
//  req      in         req_type, position, value_in
//  rsp      out        status, read_value, count
//
//  From transfer to result: the cells act at the transfer edge, then a cell
//  read stage and a group merge stage feed the result register. The merge of
//  the read data across the row sets how many stages there are. A new request
//  is taken in the cycle its predecessor's result transfers, so the engine
//  works on one request at a time.
//  Reset clears the length and the control; the entries need no clearing.
//  A stalled result holds the engine; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module indexed_list_engine_core (
    input  logic          clk,
    input  logic          rst_n,
    ile_req_if.sink       req,
    ile_rsp_if.source     rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MERGE,
        S_SEND
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [ile_pkg::LEN_W-1:0]           length_reg;
    logic [ile_pkg::LEN_W-1:0]           length_next;
    logic [1:0]                          stat_pend_reg;
    logic [1:0]                          stat_next;
    logic [1:0]                          status_reg;
    logic signed [ile_pkg::DATA_W-1:0]   value_reg;
    logic signed [ile_pkg::DATA_W-1:0]   merged;
    logic [ile_pkg::COUNT_W-1:0]         count_reg;
    logic                                accept;
    logic                                full;
    logic [ile_pkg::CMP_W-1:0]           pos_ext;
    logic [ile_pkg::CMP_W-1:0]           len_ext;
    ile_pkg::cell_cmd_t                  cmd;
    ile_pkg::cell_cmd_t                  cmd_dec;
    logic signed [ile_pkg::DATA_W-1:0]   group_rd [ile_pkg::NGROUP];

    // Handshake: idle, or the waiting result transfers in this cycle.
    assign req.ready = (state_reg == S_IDLE) || ((state_reg == S_SEND) && rsp.ready);
    assign accept    = req.valid && req.ready;

    assign full    = (length_reg == ile_pkg::LEN_W'(ile_pkg::CAPACITY));
    assign pos_ext = ile_pkg::CMP_W'(req.position);
    assign len_ext = ile_pkg::CMP_W'(length_reg);

    // Request decode: range and full checks, cell command and new length.
    always_comb
    begin
        stat_next     = ile_pkg::STAT_OK;
        length_next   = length_reg;
        cmd_dec.op    = ile_pkg::OP_HOLD;
        cmd_dec.at    = pos_ext;
        cmd_dec.value = req.value_in;
        unique case (req.req_type)
            ile_pkg::REQ_READ:
            begin
                if (pos_ext >= len_ext)
                begin
                    stat_next = ile_pkg::STAT_RANGE;
                end
                else
                begin
                    cmd_dec.op = ile_pkg::OP_READ;
                end
            end
            ile_pkg::REQ_INS_HEAD:
            begin
                cmd_dec.at = '0;
                if (full)
                begin
                    stat_next = ile_pkg::STAT_FULL;
                end
                else
                begin
                    cmd_dec.op  = ile_pkg::OP_INSERT;
                    length_next = length_reg + ile_pkg::LEN_W'(1);
                end
            end
            ile_pkg::REQ_APPEND:
            begin
                cmd_dec.at = len_ext;
                if (full)
                begin
                    stat_next = ile_pkg::STAT_FULL;
                end
                else
                begin
                    cmd_dec.op  = ile_pkg::OP_INSERT;
                    length_next = length_reg + ile_pkg::LEN_W'(1);
                end
            end
            ile_pkg::REQ_INS_POS:
            begin
                if (pos_ext > len_ext)
                begin
                    stat_next = ile_pkg::STAT_RANGE;
                end
                else if (full)
                begin
                    stat_next = ile_pkg::STAT_FULL;
                end
                else
                begin
                    cmd_dec.op  = ile_pkg::OP_INSERT;
                    length_next = length_reg + ile_pkg::LEN_W'(1);
                end
            end
            ile_pkg::REQ_DELETE:
            begin
                if (pos_ext >= len_ext)
                begin
                    stat_next = ile_pkg::STAT_RANGE;
                end
                else
                begin
                    cmd_dec.op  = ile_pkg::OP_DELETE;
                    length_next = length_reg - ile_pkg::LEN_W'(1);
                end
            end
            default:
            begin
                stat_next = ile_pkg::STAT_OK;
            end
        endcase
    end

    // Cells act only on the edge of a request transfer.
    always_comb
    begin
        cmd = cmd_dec;
        if (!accept)
        begin
            cmd.op = ile_pkg::OP_HOLD;
        end
    end

    ile_chain u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .group_rd (group_rd)
    );

    // Final merge of the group read data.
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < ile_pkg::NGROUP; g++)
        begin
            merged = merged | group_rd[g];
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
                else if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, length and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            length_reg    <= '0;
            stat_pend_reg <= ile_pkg::STAT_OK;
            status_reg    <= ile_pkg::STAT_OK;
            value_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                length_reg    <= length_next;
                stat_pend_reg <= stat_next;
            end
            if (state_reg == S_MERGE)
            begin
                status_reg <= stat_pend_reg;
                value_reg  <= merged;
                count_reg  <= ile_pkg::COUNT_W'(length_reg);
            end
        end
    end

    assign rsp.valid      = (state_reg == S_SEND);
    assign rsp.status     = status_reg;
    assign rsp.read_value = value_reg;
    assign rsp.count      = count_reg;

`ifndef SYNTH
    // The length never passes the store size.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= ile_pkg::LEN_W'(ile_pkg::CAPACITY))
        else $error("length beyond capacity");

    // The length moves only at a request transfer.
    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(length_reg))
        else $error("length changed without a request");

    // A full status is only reported while the store is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ile_pkg::STAT_FULL)
            |-> length_reg == ile_pkg::LEN_W'(ile_pkg::CAPACITY))
        else $error("full status with room left");

    // Failed requests carry zero read data.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ile_pkg::STAT_OK) |-> rsp.read_value == '0)
        else $error("nonzero read data on a failed request");

    // A transfer starts the read stage on the next cycle.
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_READ)
        else $error("request transfer did not start the pipeline");
`endif

endmodule

@@ tb/ile_list_checker.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine result checker
// Watches the request and response channels. It keeps its own copy of the
// stored sequence, works out the result of every request transfer, and
// compares each response transfer field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module ile_list_checker (
    input  logic  clk,
    input  logic  rst_n,
    ile_req_if    req,
    ile_rsp_if    rsp,
    output int    mismatches,
    output int    pending,
    output int    checked,
    output int    range_hits,
    output int    full_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]                        status;
        logic signed [ile_pkg::DATA_W-1:0] read_value;
        logic [ile_pkg::COUNT_W-1:0]       count;
    } list_result_t;

    // Shadow of the stored sequence, head first.
    logic signed [ile_pkg::DATA_W-1:0] list_values[$];
    // Results owed by the engine, oldest first.
    list_result_t                      owed_results[$];

    int error_count;
    int checked_count;
    int range_count;
    int full_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Applies one request to the shadow sequence and returns its result.
    function automatic list_result_t apply_request(
        input logic [2:0]                        kind,
        input logic [ile_pkg::POS_W-1:0]         pos,
        input logic signed [ile_pkg::DATA_W-1:0] val);
        list_result_t res;
        int           len;
        int           at;
        len            = list_values.size();
        at             = int'(pos);
        res.status     = ile_pkg::STAT_OK;
        res.read_value = '0;
        case (kind)
            ile_pkg::REQ_READ:
            begin
                if (at >= len)
                    res.status = ile_pkg::STAT_RANGE;
                else
                    res.read_value = list_values[at];
            end
            ile_pkg::REQ_INS_HEAD:
            begin
                if (len >= ile_pkg::CAPACITY)
                    res.status = ile_pkg::STAT_FULL;
                else
                    list_values.push_front(val);
            end
            ile_pkg::REQ_APPEND:
            begin
                if (len >= ile_pkg::CAPACITY)
                    res.status = ile_pkg::STAT_FULL;
                else
                    list_values.push_back(val);
            end
            ile_pkg::REQ_INS_POS:
            begin
                // The range test wins over the full test.
                if (at > len)
                    res.status = ile_pkg::STAT_RANGE;
                else if (len >= ile_pkg::CAPACITY)
                    res.status = ile_pkg::STAT_FULL;
                else
                    list_values.insert(at, val);
            end
            ile_pkg::REQ_DELETE:
            begin
                if (at >= len)
                    res.status = ile_pkg::STAT_RANGE;
                else
                    list_values.delete(at);
            end
            default:
            begin
                // Unknown kinds leave the sequence alone.
            end
        endcase
        res.count = ile_pkg::COUNT_W'(list_values.size());
        return res;
    endfunction

    // Predict on request transfers, compare on response transfers.
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            list_values.delete();
            owed_results.delete();
            error_count   = 0;
            checked_count = 0;
            range_count   = 0;
            full_count    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                checked_count++;
                if (rsp.status == ile_pkg::STAT_RANGE)
                    range_count++;
                if (rsp.status == ile_pkg::STAT_FULL)
                    full_count++;
                if (owed_results.size() == 0)
                begin
                    report_mismatch("response with no request outstanding, status",
                                    32'(rsp.status), 32'hx);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 32'(rsp.status), 32'(want.status));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.count !== want.count)
                        report_mismatch("count", 32'(rsp.count), 32'(want.count));
                end
            end
            if (req.valid && req.ready)
                owed_results.push_back(apply_request(req.req_type, req.position,
                                                     req.value_in));
        end
        mismatches <= error_count;
        pending    <= owed_results.size();
        checked    <= checked_count;
        range_hits <= range_count;
        full_hits  <= full_count;
    end

endmodule

@@ tb/indexed_list_engine_core_tb.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives directed and random list requests with random gaps on both channels,
// lets the list checker predict and compare every response, and prints the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module indexed_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 800;

    logic clk;
    logic rst_n;

    ile_req_if req_ch ();
    ile_rsp_if rsp_ch ();

    int mismatches;
    int pending;
    int checked;
    int range_hits;
    int full_hits;

    // Set during stretches where neither side idles.
    bit no_idle;
    // Length the engine should hold after the requests sent so far.
    int list_len;
    int kind_sent[8];

    indexed_list_engine_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    ile_list_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .range_hits (range_hits),
        .full_hits  (full_hits)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog for a hung engine.
    initial
    begin
        #500_000;
        $display("Timeout: responses stopped arriving");
        $display("Mismatches found");
        $finish;
    end

    // Length bookkeeping so random positions mostly land inside the list.
    function automatic int next_length(input logic [2:0] kind, input int pos, input int len);
        int res;
        res = len;
        case (kind)
            ile_pkg::REQ_INS_HEAD, ile_pkg::REQ_APPEND:
                if (len < ile_pkg::CAPACITY)
                    res = len + 1;
            ile_pkg::REQ_INS_POS:
                if (pos <= len && len < ile_pkg::CAPACITY)
                    res = len + 1;
            ile_pkg::REQ_DELETE:
                if (pos < len)
                    res = len - 1;
            default:
                res = len;
        endcase
        return res;
    endfunction

    function automatic logic signed [ile_pkg::DATA_W-1:0] pick_value();
        logic signed [ile_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = -32'sd1;
            3:       v = '0;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offers one request after a random gap and returns at its transfer edge.
    task automatic send_request(input logic [2:0] kind,
                                input logic [ile_pkg::POS_W-1:0] pos,
                                input logic signed [ile_pkg::DATA_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.position <= pos;
        req_ch.value_in <= val;
        do @(posedge clk); while (!req_ch.ready);
        kind_sent[kind]++;
        list_len = next_length(kind, int'(pos), list_len);
    endtask

    // Stops sending until every owed response has come back.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Response side: random stall before each transfer.
    initial
    begin
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
        end
    end

    // Reset, stimulus and verdict.
    initial
    begin
        logic [2:0]                  kind;
        logic [ile_pkg::POS_W-1:0]   pos;
        int                          counted;
        int                          roll;
        int                          full_tries;
        bit                          growing;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= ile_pkg::REQ_READ;
        req_ch.position <= '0;
        req_ch.value_in <= '0;
        no_idle         = 1'b0;
        list_len        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty store, field extremes, ends of the list.
        send_request(ile_pkg::REQ_READ,     7'd0, 32'sd5);
        send_request(ile_pkg::REQ_DELETE,   7'd0, 32'sd5);
        send_request(ile_pkg::REQ_INS_POS,  7'd1, 32'sd7);
        send_request(ile_pkg::REQ_INS_POS,  7'd0, 32'sh7fff_ffff);
        send_request(ile_pkg::REQ_INS_HEAD, 7'd0, 32'sh8000_0000);
        send_request(ile_pkg::REQ_APPEND,   7'd127, -32'sd1);
        // Insert at position equal to the length lands at the tail.
        send_request(ile_pkg::REQ_INS_POS,  7'd3, 32'sd0);
        for (int i = 0; i < 4; i++)
            send_request(ile_pkg::REQ_READ, ile_pkg::POS_W'(i), 32'sd0);
        send_request(ile_pkg::REQ_READ,     7'd4, 32'sd0);
        send_request(ile_pkg::REQ_READ,     7'd127, 32'sh5555_aaaa);
        send_request(ile_pkg::REQ_DELETE,   7'd127, 32'sd0);
        send_request(ile_pkg::REQ_INS_POS,  7'd127, 32'sd9);
        send_request(ile_pkg::REQ_INS_POS,  7'd64, 32'sd9);
        send_request(ile_pkg::REQ_DELETE,   7'd1, 32'sd0);
        send_request(ile_pkg::REQ_DELETE,   7'd2, 32'sd0);
        send_request(3'd5, 7'd0, 32'sh1234_5678);
        send_request(3'd6, 7'd127, -32'sd1);
        send_request(3'd7, 7'd64, 32'sh8000_0000);
        drain_responses();

        // Random part: alternate growing to full and shrinking to empty.
        counted    = 0;
        full_tries = 0;
        growing    = 1'b1;
        while (counted < RANDOM_ITEMS)
        begin
            no_idle = (counted % 150) >= 110;
            if (counted == RANDOM_ITEMS / 2)
                drain_responses();
            if (growing && list_len == ile_pkg::CAPACITY)
            begin
                full_tries++;
                if (full_tries > 4)
                begin
                    growing    = 1'b0;
                    full_tries = 0;
                end
            end
            else if (!growing && list_len == 0)
            begin
                growing = 1'b1;
            end

            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                // Noise: any kind, any position.
                kind = 3'($urandom_range(0, 7));
                pos  = ile_pkg::POS_W'($urandom_range(0, 127));
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 25)
                    kind = ile_pkg::REQ_READ;
                else if ((growing && roll < 85) || (!growing && roll < 40))
                    kind = 3'($urandom_range(ile_pkg::REQ_INS_HEAD, ile_pkg::REQ_INS_POS));
                else
                    kind = ile_pkg::REQ_DELETE;
                if (kind == ile_pkg::REQ_INS_POS)
                    pos = ile_pkg::POS_W'($urandom_range(0, list_len));
                else
                    pos = (list_len > 0) ?
                          ile_pkg::POS_W'($urandom_range(0, list_len - 1)) : '0;
            end
            send_request(kind, pos, pick_value());
            if (kind <= ile_pkg::REQ_DELETE)
                counted++;
        end

        // Wind down and let the last response settle.
        no_idle = 1'b0;
        drain_responses();
        repeat (10) @(posedge clk);

        $display("Sent %0d reads, %0d head inserts, %0d tail appends, %0d position inserts,",
                 kind_sent[ile_pkg::REQ_READ], kind_sent[ile_pkg::REQ_INS_HEAD],
                 kind_sent[ile_pkg::REQ_APPEND], kind_sent[ile_pkg::REQ_INS_POS]);
        $display("%0d deletes, %0d unknown kinds; %0d responses checked,",
                 kind_sent[ile_pkg::REQ_DELETE], kind_sent[5] + kind_sent[6] + kind_sent[7],
                 checked);
        $display("%0d out of range, %0d full", range_hits, full_hits);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ile_pkg.sv
rtl/core/ile_if.sv
rtl/core/ile_cell.sv
rtl/core/ile_chain.sv
rtl/core/indexed_list_engine_core.sv
tb/ile_list_checker.sv
tb/indexed_list_engine_core_tb.sv
